>>> rtl/i2cmdq_pkg.sv
// ----------------------------------------------------------------------------
// i2cmdq_pkg
// Types and codes shared by the multi-target i2c command queue.
// ----------------------------------------------------------------------------
package i2cmdq_pkg;

  localparam int ENTRY_W = 12;

  typedef enum logic [1:0] {
    OP_ENQUEUE   = 2'd0,
    OP_BUS_EVENT = 2'd1,
    OP_READ      = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REFUSED  = 2'd1,
    STAT_READ_ERR = 2'd2
  } status_t;

  localparam logic [3:0] CMD_ERROR   = 4'd0;
  localparam logic [3:0] CMD_START   = 4'd1;
  localparam logic [3:0] CMD_SEND    = 4'd2;
  localparam logic [3:0] CMD_RESTART = 4'd3;
  localparam logic [3:0] CMD_RECEIVE = 4'd4;
  localparam logic [3:0] CMD_ACK     = 4'd5;
  localparam logic [3:0] CMD_NACK    = 4'd6;
  localparam logic [3:0] CMD_STOP    = 4'd7;
  localparam logic [3:0] CMD_END     = 4'd8;

  localparam logic [2:0] ACT_NONE = 3'd0;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // first member is the top bits
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] rx_data;
    logic [6:0] remaining;
    logic [7:0] entry_byte;
    logic [3:0] entry_command;
    logic [1:0] target;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pad;
    logic [1:0] active_target;
    logic       running;
    logic [3:0] read_tag;
    logic [7:0] read_byte;
    logic       kick;
    logic [7:0] send_byte;
    logic [2:0] bus_action;
    status_t    status;
  } out_item_t;

endpackage

>>> rtl/i2cmdq_ram.sv
// ----------------------------------------------------------------------------
// i2cmdq_ram
// Simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module i2cmdq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/i2c_multi_device_command_queue.sv
// ----------------------------------------------------------------------------
// i2c_multi_device_command_queue
// Per-target i2c command queues and receive queues driven by bus events.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                | payload
//  s_*      | in  | s_tvalid / s_tready      | tuser: cmd; tdata: item fields
//  m_*      | out | m_tvalid / m_tready      | tdata: one result per item
//
//  the accept cycle (idle state) reads the send or receive ram; in the
//  exec state the item modifies the queue pointers, writes back and loads
//  the output register. an item stays in the exec state while the output
//  register holds a result that is not taken; a new item is taken while
//  a result waits. reset clears pointers and counts; the rams need no
//  clearing since only entries below the fill count are read.
// ----------------------------------------------------------------------------
module i2c_multi_device_command_queue #(
  parameter int TARGETS    = 4,
  parameter int SEND_DEPTH = 64,
  parameter int RECV_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // target, entry_command, entry_byte, remaining, rx_data, zero pad
  input  i2cmdq_pkg::in_item_t  s_tdata,
  // cmd
  input  i2cmdq_pkg::op_t       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status, bus_action, send_byte, kick, read_byte, read_tag, running,
  // active_target, zero pad
  output i2cmdq_pkg::out_item_t m_tdata
);

  import i2cmdq_pkg::*;

  localparam int TW   = (TARGETS > 4) ? $clog2(TARGETS) : 2;
  localparam int SIW  = $clog2(SEND_DEPTH);
  localparam int RIW  = $clog2(RECV_DEPTH);
  localparam int RCW  = $clog2(RECV_DEPTH + 1);
  localparam int SUMW = ((SIW > 7) ? SIW : 7) + 1;
  localparam int SAW  = TW + SIW;
  localparam int RAW  = TW + RIW;

  // queue pointers per target
  logic [SIW-1:0] snd_head [TARGETS];
  logic [SIW-1:0] snd_cnt  [TARGETS];
  logic [RCW-1:0] rcv_head [TARGETS];
  logic [RCW-1:0] rcv_cnt  [TARGETS];
  logic           busy, busy_next;
  logic           expect_byte, expect_next;
  logic [TW-1:0]  serving, serving_next;

  fsm_t      state, state_next;
  in_item_t  item;
  op_t       op;
  out_item_t res;

  logic accept, out_free, commit;

  // ram ports
  logic               snd_we, rcv_we, snd_re, rcv_re;
  logic [SAW-1:0]     snd_wr_addr, snd_rd_addr;
  logic [RAW-1:0]     rcv_wr_addr, rcv_rd_addr;
  logic [ENTRY_W-1:0] snd_wr_data, snd_rd_data, rcv_wr_data, rcv_rd_data;

  // pointer updates
  logic           sh_we, sc_we, rh_we, rc_we;
  logic [SIW-1:0] sh_val, sc_val;
  logic [RCW-1:0] rh_val, rc_val;

  logic [TW-1:0]  tg_in, tg, sel, found_idx;
  logic           tg_in_ok, tg_ok, found, has_entry;
  logic [SIW-1:0] sh, sc;
  logic [RCW-1:0] rh, rc;
  logic [3:0]     cur;
  logic [7:0]     cb;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == FSM_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= s_tdata;
      op   <= s_tuser;
    end
  end

  // ram reads issued in the accept cycle
  assign tg_in       = TW'(s_tdata.target);
  assign tg_in_ok    = int'(s_tdata.target) < TARGETS;
  assign snd_re      = accept && (s_tuser == OP_BUS_EVENT);
  assign rcv_re      = accept && (s_tuser == OP_READ);
  assign snd_rd_addr = {serving, snd_head[serving]};
  assign rcv_rd_addr = tg_in_ok ? {tg_in, rcv_head[tg_in][RIW-1:0]} : '0;

  i2cmdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (1 << SAW)
  ) u_send_ram (
    .clk     (clk),
    .wr_en   (snd_we && commit),
    .wr_addr (snd_wr_addr),
    .wr_data (snd_wr_data),
    .rd_en   (snd_re),
    .rd_addr (snd_rd_addr),
    .rd_data (snd_rd_data)
  );

  i2cmdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (1 << RAW)
  ) u_recv_ram (
    .clk     (clk),
    .wr_en   (rcv_we && commit),
    .wr_addr (rcv_wr_addr),
    .wr_data (rcv_wr_data),
    .rd_en   (rcv_re),
    .rd_addr (rcv_rd_addr),
    .rd_data (rcv_rd_data)
  );

  // highest-numbered other target with entries waiting
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < TARGETS; i++) begin
      if (TW'(i) != serving && snd_cnt[i] > snd_head[i]) begin
        found     = 1'b1;
        found_idx = TW'(i);
      end
    end
  end

  assign tg    = TW'(item.target);
  assign tg_ok = int'(item.target) < TARGETS;
  assign sel   = (op == OP_BUS_EVENT) ? serving : (tg_ok ? tg : '0);
  assign sh    = snd_head[sel];
  assign sc    = snd_cnt[sel];
  assign rh    = rcv_head[sel];
  assign rc    = rcv_cnt[sel];

  assign has_entry = sh < sc;
  assign cur       = has_entry ? snd_rd_data[11:8] : CMD_END;
  assign cb        = has_entry ? snd_rd_data[7:0] : 8'd0;

  always_comb begin
    res          = '0;
    res.status   = STAT_OK;
    res.bus_action = ACT_NONE;
    busy_next    = busy;
    serving_next = serving;
    expect_next  = expect_byte;
    snd_we       = 1'b0;
    snd_wr_addr  = {sel, sc};
    snd_wr_data  = {item.entry_command, item.entry_byte};
    rcv_we       = 1'b0;
    rcv_wr_addr  = {sel, rc[RIW-1:0]};
    rcv_wr_data  = {cur, item.rx_data};
    sh_we        = 1'b0;
    sh_val       = sh + 1'b1;
    sc_we        = 1'b0;
    sc_val       = sc + 1'b1;
    rh_we        = 1'b0;
    rh_val       = rh + 1'b1;
    rc_we        = 1'b0;
    rc_val       = rc + 1'b1;

    case (op)
      OP_ENQUEUE: begin
        if (!tg_ok || (SUMW'(sc) + SUMW'(item.remaining) >= SUMW'(SEND_DEPTH - 1))) begin
          res.status = STAT_REFUSED;
        end else begin
          snd_we = 1'b1;
          sc_we  = 1'b1;
          if (item.remaining <= 7'd1 && !busy) begin
            serving_next = sel;
            busy_next    = 1'b1;
            res.kick     = 1'b1;
          end
        end
      end
      OP_BUS_EVENT: begin
        if (busy) begin
          // byte from the previous receive is stored first
          if (expect_byte) begin
            expect_next = 1'b0;
            if (rc < RCW'(RECV_DEPTH)) begin
              rcv_we = 1'b1;
              rc_we  = 1'b1;
            end
          end
          case (cur) inside
            CMD_START, CMD_SEND, CMD_RESTART, CMD_RECEIVE,
            CMD_ACK, CMD_NACK, CMD_STOP: begin
              res.bus_action = cur[2:0];
              if (cur == CMD_SEND) begin
                res.send_byte = cb;
              end
              if (cur == CMD_RECEIVE) begin
                expect_next = 1'b1;
              end
              sh_we = 1'b1;
            end
            CMD_END: begin
              if ((SUMW'(sh) + SUMW'(1)) >= SUMW'(sc)) begin
                // queue done: clear it and hand over to another waiting target, if any
                busy_next = 1'b0;
                sh_we     = 1'b1;
                sh_val    = '0;
                sc_we     = 1'b1;
                sc_val    = '0;
                if (found) begin
                  serving_next = found_idx;
                  busy_next    = 1'b1;
                  res.kick     = 1'b1;
                end
              end else begin
                res.kick = 1'b1;
                sh_we    = 1'b1;
              end
            end
            default: sh_we = 1'b1;
          endcase
        end
      end
      OP_READ: begin
        if (!tg_ok || rc >= RCW'(RECV_DEPTH - 1) || rh >= rc) begin
          res.status = STAT_READ_ERR;
        end else begin
          res.read_byte = rcv_rd_data[7:0];
          res.read_tag  = rcv_rd_data[11:8];
          rh_we         = 1'b1;
          if (rh_val >= rc) begin
            rh_val = '0;
            rc_we  = 1'b1;
            rc_val = '0;
          end
        end
      end
      default: ;
    endcase

    res.running       = busy_next;
    res.active_target = serving_next[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      serving     <= '0;
      expect_byte <= 1'b0;
      for (int i = 0; i < TARGETS; i++) begin
        snd_head[i] <= '0;
        snd_cnt[i]  <= '0;
        rcv_head[i] <= '0;
        rcv_cnt[i]  <= '0;
      end
    end else if (commit) begin
      busy        <= busy_next;
      serving     <= serving_next;
      expect_byte <= expect_next;
      if (sh_we) begin
        snd_head[sel] <= sh_val;
      end
      if (sc_we) begin
        snd_cnt[sel] <= sc_val;
      end
      if (rh_we) begin
        rcv_head[sel] <= rh_val;
      end
      if (rc_we) begin
        rcv_cnt[sel] <= rc_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= res;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == FSM_EXEC) && !s_tready)
    else $error("accepted item did not enter execution");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid && (m_tdata.running == busy)
              && (m_tdata.active_target == serving[1:0]))
    else $error("result register does not match engine state");

  a_head_within_count: assert property (@(posedge clk) disable iff (rst)
    snd_head[serving] <= snd_cnt[serving])
    else $error("send head passed send count");

endmodule
